### hdl/bsa_pkg.sv
// Package for the button setpoint auto-repeat block.
// Holds register indexes, reset values, shared types and the setpoint step functions.
// No dependencies.
`default_nettype none

package bsa_pkg;

  // Configuration port geometry
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_HOLD_MS     = 3'd0,
    REG_REPEAT_MS   = 3'd1,
    REG_DEBOUNCE_MS = 3'd2,
    REG_SHORT_STEP  = 3'd3,
    REG_LONG_STEP   = 3'd4,
    REG_MAX_VALUE   = 3'd5,
    REG_START_VALUE = 3'd6
  } bsa_reg_t;

  // Register values after reset
  localparam logic [15:0] HOLD_MS_RST     = 16'd1000;
  localparam logic [15:0] REPEAT_MS_RST   = 16'd500;
  localparam logic [7:0]  DEBOUNCE_MS_RST = 8'd10;
  localparam logic [7:0]  SHORT_STEP_RST  = 8'd1;
  localparam logic [7:0]  LONG_STEP_RST   = 8'd10;
  localparam logic [7:0]  MAX_VALUE_RST   = 8'd100;
  localparam logic [7:0]  START_VALUE_RST = 8'd50;

  // Timing settings shared by both button trackers
  typedef struct packed {
    logic [15:0] hold_ms;
    logic [15:0] repeat_ms;
    logic [7:0]  debounce_ms;
  } bsa_timing_t;

  // Step requests raised by one button tracker in one tick
  typedef struct packed {
    logic long_ev;
    logic short_ev;
  } bsa_event_t;

  // Increment with saturation at the upper limit. A short step does nothing
  // once the value has reached or passed the limit.
  function automatic logic [7:0] step_up(input logic [7:0] val, input logic [7:0] amt,
                                         input logic [7:0] lim, input logic is_long);
    logic [8:0] sum;
    logic [7:0] res;
    sum = {1'b0, val} + {1'b0, amt};
    res = (sum > {1'b0, lim}) ? lim : sum[7:0];
    if (!is_long && (val >= lim)) begin
      res = val;
    end
    return res;
  endfunction

  // Decrement with saturation at zero
  function automatic logic [7:0] step_down(input logic [7:0] val, input logic [7:0] amt);
    return (val >= amt) ? (val - amt) : 8'd0;
  endfunction

endpackage

`default_nettype wire

### hdl/button_setpoint_autorepeat.sv
// Top level of the up/down button setpoint with auto repeat.
// Depends on bsa_pkg and instantiates bsa_button for each button.
//
//  Port group | Direction | Word contents
//  in_        | slave     | tick: inc_pressed, dec_pressed, reload
//  out_       | master    | setpoint_value, inc_held, dec_held after the tick
//  cfg_       | write     | register index and data, no read-back
//
// One tick word enters an input register and is processed once the output
// side can advance; the state registers then present the result word. A new
// word is taken every cycle while the out_ side is not stalled. The throughput
// is set by the state update of the two trackers and the setpoint chain.
// rst_n is synchronous and restores register defaults and clears the valid flags, trackers and setpoint.
// A stall on the out_ side holds the result and backs up through in_tready.
`default_nettype none

module button_setpoint_autorepeat #(
  parameter int TIME_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [7:0]                     in_tdata,  // inc_pressed, dec_pressed, reload
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [15:0]                         out_tdata, // setpoint_value[7:0], inc_held, dec_held
  input  wire logic                           cfg_we,
  input  wire logic [bsa_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [bsa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bsa_pkg::*;

  // Configuration registers
  logic [15:0] hold_ms_r, repeat_ms_r;
  logic [7:0]  debounce_ms_r, short_step_r, long_step_r, max_value_r, start_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ms_r     <= HOLD_MS_RST;
      repeat_ms_r   <= REPEAT_MS_RST;
      debounce_ms_r <= DEBOUNCE_MS_RST;
      short_step_r  <= SHORT_STEP_RST;
      long_step_r   <= LONG_STEP_RST;
      max_value_r   <= MAX_VALUE_RST;
      start_value_r <= START_VALUE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_HOLD_MS:     hold_ms_r     <= cfg_wdata;
        REG_REPEAT_MS:   repeat_ms_r   <= cfg_wdata;
        REG_DEBOUNCE_MS: debounce_ms_r <= cfg_wdata[7:0];
        REG_SHORT_STEP:  short_step_r  <= cfg_wdata[7:0];
        REG_LONG_STEP:   long_step_r   <= cfg_wdata[7:0];
        REG_MAX_VALUE:   max_value_r   <= cfg_wdata[7:0];
        REG_START_VALUE: start_value_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Input register and flow control
  logic s1_valid_r, s1_valid_nxt;
  logic s1_inc_r, s1_dec_r, s1_reload_r;
  logic out_valid_r, out_valid_nxt;
  logic advance, fire;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  assign s1_valid_nxt  = (in_tvalid && in_tready) ? 1'b1 : (fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_inc_r    <= in_tdata[0];
      s1_dec_r    <= in_tdata[1];
      s1_reload_r <= in_tdata[2];
    end
  end

  // Button trackers
  bsa_timing_t timing;
  bsa_event_t  inc_ev, dec_ev;
  logic        inc_trk, dec_trk;
  logic        tick_en, reload_en;

  assign timing    = '{hold_ms: hold_ms_r, repeat_ms: repeat_ms_r, debounce_ms: debounce_ms_r};
  assign tick_en   = fire && !s1_reload_r;
  assign reload_en = fire && s1_reload_r;

  bsa_button #(.TIME_WIDTH(TIME_WIDTH)) u_inc (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick_en  (tick_en),
    .clr      (reload_en),
    .level    (s1_inc_r),
    .timing   (timing),
    .ev       (inc_ev),
    .tracking (inc_trk)
  );

  bsa_button #(.TIME_WIDTH(TIME_WIDTH)) u_dec (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick_en  (tick_en),
    .clr      (reload_en),
    .level    (s1_dec_r),
    .timing   (timing),
    .ev       (dec_ev),
    .tracking (dec_trk)
  );

  // Setpoint chain: increment step first, then decrement step; a reload overrides both
  logic [7:0] value_r, value_nxt, after_inc;

  always_comb begin
    after_inc = value_r;
    if (inc_ev.long_ev) begin
      after_inc = step_up(value_r, long_step_r, max_value_r, 1'b1);
    end else if (inc_ev.short_ev) begin
      after_inc = step_up(value_r, short_step_r, max_value_r, 1'b0);
    end
    value_nxt = after_inc;
    if (dec_ev.long_ev) begin
      value_nxt = step_down(after_inc, long_step_r);
    end else if (dec_ev.short_ev) begin
      value_nxt = step_down(after_inc, short_step_r);
    end
    if (s1_reload_r) begin
      value_nxt = (start_value_r > max_value_r) ? max_value_r : start_value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= 8'd0;
    end else if (fire) begin
      value_r <= value_nxt;
    end
  end

  // The state registers double as the result register
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, dec_trk, inc_trk, value_r};

  // Checks
  a_fire_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_tvalid)
    else $error("processed tick did not produce a result word");

  a_reload_clears: assert property (@(posedge clk) disable iff (!rst_n)
    reload_en |=> (!inc_trk && !dec_trk))
    else $error("reload left a press tracked");

  a_stall_holds_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(value_r))
    else $error("setpoint changed while the result word was stalled");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input not ready with an empty input register");

endmodule

`default_nettype wire

### hdl/bsa_button.sv
// Press tracker for one button: debounce, press timing and repeat timing.
// Depends on bsa_pkg for the timing and event structs.
`default_nettype none

module bsa_button #(
  parameter int TIME_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                tick_en,   // process one tick
  input  wire logic                clr,       // reload: drop all tracking
  input  wire logic                level,
  input  wire bsa_pkg::bsa_timing_t timing,
  output bsa_pkg::bsa_event_t      ev,
  output logic                     tracking
);
  import bsa_pkg::*;

  localparam int CMP_W = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;

  logic                  trk_r, trk_nxt;
  logic [TIME_WIDTH-1:0] pt_r, pt_nxt;
  logic [TIME_WIDTH-1:0] sr_r, sr_nxt;
  logic [7:0]            deb_r, deb_nxt;

  logic [TIME_WIDTH-1:0] pt_tick, sr_tick;
  logic [7:0]            deb_inc;
  logic                  past_hold, past_repeat;

  // Time counters run while a press is tracked, saturating at all ones
  always_comb begin
    pt_tick = pt_r;
    sr_tick = sr_r;
    if (trk_r) begin
      pt_tick = (pt_r == '1) ? pt_r : pt_r + TIME_WIDTH'(1);
      sr_tick = (sr_r == '1) ? sr_r : sr_r + TIME_WIDTH'(1);
    end
  end

  assign past_hold   = CMP_W'(pt_tick) >= CMP_W'(timing.hold_ms);
  assign past_repeat = CMP_W'(sr_tick) >= CMP_W'(timing.repeat_ms);
  assign deb_inc     = (deb_r == 8'hFF) ? deb_r : deb_r + 8'd1;

  // Next state and step requests for this tick
  always_comb begin
    trk_nxt = trk_r;
    pt_nxt  = pt_tick;
    sr_nxt  = sr_tick;
    deb_nxt = deb_r;
    ev      = '0;
    if (level == trk_r) begin
      deb_nxt = 8'd0;
      if (trk_r && past_hold && past_repeat) begin
        sr_nxt     = '0;
        ev.long_ev = 1'b1;
      end
    end else if (deb_inc < timing.debounce_ms) begin
      deb_nxt = deb_inc;
    end else begin
      deb_nxt = 8'd0;
      if (!trk_r) begin
        trk_nxt = 1'b1;
        pt_nxt  = '0;
        sr_nxt  = '0;
      end else begin
        trk_nxt     = 1'b0;
        ev.short_ev = !past_hold;
      end
    end
  end

  // Tracker registers
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      trk_r <= 1'b0;
      pt_r  <= '0;
      sr_r  <= '0;
      deb_r <= 8'd0;
    end else if (tick_en) begin
      trk_r <= trk_nxt;
      pt_r  <= pt_nxt;
      sr_r  <= sr_nxt;
      deb_r <= deb_nxt;
    end
  end

  assign tracking = trk_r;

endmodule

`default_nettype wire

### test/button_setpoint_autorepeat_tb.sv
// Self-checking testbench for the button setpoint block with auto repeat.
// Depends on bsa_pkg and button_setpoint_autorepeat; it drives tick words,
// mirrors the debounce, hold and repeat logic, and checks every result word.
`timescale 1ns / 100ps

module button_setpoint_autorepeat_tb;
  import bsa_pkg::*;

  localparam int TW = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES = 10;

  // Positions of the tick fields in in_tdata
  localparam int INC_BIT    = 0;
  localparam int DEC_BIT    = 1;
  localparam int RELOAD_BIT = 2;
  localparam logic [2:0] TICK_NONE   = 3'b000;
  localparam logic [2:0] TICK_INC    = 3'b001;
  localparam logic [2:0] TICK_DEC    = 3'b010;
  localparam logic [2:0] TICK_RELOAD = 3'b100;

  // One result word, laid out as in out_tdata[9:0]
  typedef struct packed {
    logic       dec_held;
    logic       inc_held;
    logic [7:0] value;
  } setpoint_word_t;

  // Press tracking of one button
  typedef struct packed {
    logic          tracked;
    logic [TW-1:0] press_t;
    logic [TW-1:0] since_rep;
    logic [7:0]    bounce;
  } btn_track_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e      kind;
    logic [2:0]     bits;
    bsa_reg_t       idx;
    logic [15:0]    data;
    logic           known;
    setpoint_word_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // inc_pressed, dec_pressed, reload, zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [15:0] out_tdata;       // setpoint_value[7:0], inc_held, dec_held, zero pad
  logic        cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state and its copy of the registers
  bsa_timing_t timing_set = '{hold_ms: HOLD_MS_RST, repeat_ms: REPEAT_MS_RST,
                              debounce_ms: DEBOUNCE_MS_RST};
  logic [7:0]  short_amt = SHORT_STEP_RST;
  logic [7:0]  long_amt  = LONG_STEP_RST;
  logic [7:0]  upper_lim = MAX_VALUE_RST;
  logic [7:0]  reload_val = START_VALUE_RST;
  logic [7:0]  setpoint = '0;
  btn_track_t  inc_track = '0;
  btn_track_t  dec_track = '0;

  setpoint_word_t expected_setpoints[$];
  dir_row_t       directed_rows[$];
  int unsigned    mismatches = 0;
  int unsigned    cycle_count = 0;
  logic           in_idle_on = 1'b1;
  logic           stall_on = 1'b1;

  button_setpoint_autorepeat #(.TIME_WIDTH(TW)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Apply a short or long step in either direction to the predicted setpoint.
  function automatic void move_setpoint(input logic up, input logic is_long);
    int amt;
    int sum;
    amt = is_long ? int'(long_amt) : int'(short_amt);
    if (up) begin
      // A short step is lost once the value sits at or above the limit.
      if (is_long || setpoint < upper_lim) begin
        sum = int'(setpoint) + amt;
        setpoint = (sum > int'(upper_lim)) ? upper_lim : sum[7:0];
      end
    end else begin
      setpoint = (int'(setpoint) >= amt) ? setpoint - amt[7:0] : 8'd0;
    end
  endfunction

  // One tick of debounce, hold and repeat tracking for one button.
  function automatic void track_button(input logic level, input logic up,
                                       inout btn_track_t b);
    if (b.tracked) begin
      if (b.press_t != '1) b.press_t = b.press_t + 1'b1;
      if (b.since_rep != '1) b.since_rep = b.since_rep + 1'b1;
    end
    if (level == b.tracked) begin
      b.bounce = '0;
      if (b.tracked && b.press_t >= timing_set.hold_ms &&
          b.since_rep >= timing_set.repeat_ms) begin
        b.since_rep = '0;
        move_setpoint(up, 1'b1);
      end
    end else begin
      if (b.bounce != 8'hFF) b.bounce = b.bounce + 1'b1;
      if (b.bounce >= timing_set.debounce_ms) begin
        b.bounce = '0;
        if (!b.tracked) begin
          b.tracked = 1'b1;
          b.press_t = '0;
          b.since_rep = '0;
        end else begin
          b.tracked = 1'b0;
          if (b.press_t < timing_set.hold_ms) move_setpoint(up, 1'b0);
        end
      end
    end
  endfunction

  // Advance the predictor by one tick word and return the word it should give.
  function automatic setpoint_word_t advance_setpoint(input logic [2:0] bits);
    setpoint_word_t w;
    if (bits[RELOAD_BIT]) begin
      setpoint = (reload_val > upper_lim) ? upper_lim : reload_val;
      inc_track = '0;
      dec_track = '0;
    end else begin
      track_button(bits[INC_BIT], 1'b1, inc_track);
      track_button(bits[DEC_BIT], 1'b0, dec_track);
    end
    w.value = setpoint;
    w.inc_held = inc_track.tracked;
    w.dec_held = dec_track.tracked;
    return w;
  endfunction

  function automatic dir_row_t tick_row(input logic [2:0] bits);
    dir_row_t r;
    r = '0;
    r.kind = ROW_TICK;
    r.bits = bits;
    return r;
  endfunction

  function automatic dir_row_t chk_row(input logic [2:0] bits, input logic [7:0] v,
                                       input logic ih, input logic dh);
    dir_row_t r;
    r = tick_row(bits);
    r.known = 1'b1;
    r.want = '{dec_held: dh, inc_held: ih, value: v};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input bsa_reg_t idx, input logic [15:0] data);
    dir_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  // Length of the next level run: mostly long enough to pass the debounce,
  // sometimes a bounce that should be filtered out.
  function automatic int run_length();
    int span;
    int deb;
    deb = int'(timing_set.debounce_ms);
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, (deb > 1) ? deb - 1 : 1);
    span = int'(timing_set.hold_ms) + 3 * int'(timing_set.repeat_ms);
    if (span > 200) span = 200;
    return deb + $urandom_range(0, span);
  endfunction

  task automatic note_mismatch(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %h, got %h", field, want, got);
  endtask

  // Offer one tick word and wait for it to be taken.
  task automatic send_tick(input logic [2:0] bits, input logic known,
                           input setpoint_word_t want);
    setpoint_word_t pred;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, bits};
    do @(posedge clk); while (in_tready !== 1'b1);
    pred = advance_setpoint(bits);
    expected_setpoints.push_back(known ? want : pred);
  endtask

  task automatic pause_input();
    int n;
    n = $urandom_range(1, 4);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Register write, only once the block has drained.
  task automatic write_reg(input bsa_reg_t idx, input logic [15:0] val);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_setpoints.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HOLD_MS:     timing_set.hold_ms = val;
      REG_REPEAT_MS:   timing_set.repeat_ms = val;
      REG_DEBOUNCE_MS: timing_set.debounce_ms = val[7:0];
      REG_SHORT_STEP:  short_amt = val[7:0];
      REG_LONG_STEP:   long_amt = val[7:0];
      REG_MAX_VALUE:   upper_lim = val[7:0];
      REG_START_VALUE: reload_val = val[7:0];
      default: ;
    endcase
  endtask

  // Random button activity under the current settings.
  task automatic run_phase(input int n_ticks);
    logic       inc_lvl;
    logic       dec_lvl;
    int         inc_left;
    int         dec_left;
    logic [2:0] bits;
    inc_lvl = 1'b0;
    dec_lvl = 1'b0;
    inc_left = run_length();
    dec_left = run_length();
    for (int k = 0; k < n_ticks; k++) begin
      if (in_idle_on && $urandom_range(0, 5) == 0) pause_input();
      bits = '0;
      bits[INC_BIT] = inc_lvl;
      bits[DEC_BIT] = dec_lvl;
      if ($urandom_range(0, 79) == 0) bits[RELOAD_BIT] = 1'b1;
      if ($urandom_range(0, 24) == 0) bits = 3'($urandom_range(0, 7));
      send_tick(bits, 1'b0, '0);
      inc_left--;
      if (inc_left <= 0) begin
        inc_lvl = ~inc_lvl;
        inc_left = run_length();
      end
      dec_left--;
      if (dec_left <= 0) begin
        dec_lvl = ~dec_lvl;
        dec_left = run_length();
      end
    end
  endtask

  // Random stalls on the result side.
  always begin : ready_stall
    int n;
    @(negedge clk);
    if (stall_on && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 4);
      out_tready <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each result word with the oldest expectation.
  always @(posedge clk) begin : result_check
    setpoint_word_t got;
    setpoint_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[9:0];
      if (expected_setpoints.size() == 0) begin
        note_mismatch("unexpected word", '0, out_tdata);
      end else begin
        want = expected_setpoints.pop_front();
        if (got.value !== want.value) note_mismatch("setpoint_value", want.value, got.value);
        if (got.inc_held !== want.inc_held)
          note_mismatch("inc_held", want.inc_held, got.inc_held);
        if (got.dec_held !== want.dec_held)
          note_mismatch("dec_held", want.dec_held, got.dec_held);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("button_setpoint_autorepeat_tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t   r;
    logic [15:0] hold_v, rep_v;
    logic [7:0]  deb_v, short_v, long_v, max_v, start_v;
    int          n_ticks;

    // Directed part: reset values, reload, steps at the extremes, a value
    // above a lowered limit, and both buttons at once.
    directed_rows.push_back(chk_row(TICK_NONE, 8'd0, 1'b0, 1'b0));
    directed_rows.push_back(chk_row(TICK_RELOAD, 8'd50, 1'b0, 1'b0));
    directed_rows.push_back(chk_row(TICK_INC | TICK_DEC | TICK_RELOAD, 8'd50, 1'b0, 1'b0));
    directed_rows.push_back(cfg_row(REG_DEBOUNCE_MS, 16'd1));
    directed_rows.push_back(cfg_row(REG_HOLD_MS, 16'd3));
    directed_rows.push_back(cfg_row(REG_REPEAT_MS, 16'd1));
    directed_rows.push_back(cfg_row(REG_SHORT_STEP, 16'd255));
    directed_rows.push_back(cfg_row(REG_LONG_STEP, 16'd255));
    directed_rows.push_back(cfg_row(REG_MAX_VALUE, 16'd255));
    directed_rows.push_back(cfg_row(REG_START_VALUE, 16'd255));
    directed_rows.push_back(chk_row(TICK_RELOAD, 8'd255, 1'b0, 1'b0));
    directed_rows.push_back(chk_row(TICK_INC, 8'd255, 1'b1, 1'b0));
    directed_rows.push_back(chk_row(TICK_NONE, 8'd255, 1'b0, 1'b0));
    directed_rows.push_back(chk_row(TICK_DEC, 8'd255, 1'b0, 1'b1));
    directed_rows.push_back(chk_row(TICK_NONE, 8'd0, 1'b0, 1'b0));
    directed_rows.push_back(chk_row(TICK_INC | TICK_DEC, 8'd0, 1'b1, 1'b1));
    repeat (3) directed_rows.push_back(tick_row(TICK_INC | TICK_DEC));
    directed_rows.push_back(tick_row(TICK_INC));
    directed_rows.push_back(tick_row(TICK_NONE));
    directed_rows.push_back(cfg_row(REG_MAX_VALUE, 16'd1));
    directed_rows.push_back(tick_row(TICK_INC));
    directed_rows.push_back(tick_row(TICK_NONE));
    repeat (4) directed_rows.push_back(tick_row(TICK_INC));
    directed_rows.push_back(tick_row(TICK_DEC));
    directed_rows.push_back(tick_row(TICK_RELOAD));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.kind == ROW_WRITE) begin
        write_reg(r.idx, r.data);
      end else begin
        if (in_idle_on && $urandom_range(0, 3) == 0) pause_input();
        send_tick(r.bits, r.known, r.want);
      end
    end

    // Random phases, each under its own register settings.
    for (int p = 0; p < NUM_PHASES; p++) begin
      hold_v = 16'($urandom_range(1, 40));
      rep_v = 16'($urandom_range(1, 12));
      deb_v = 8'($urandom_range(1, 6));
      short_v = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 9)) :
                                              8'($urandom_range(1, 255));
      long_v = 8'($urandom_range(1, 255));
      max_v = 8'($urandom_range(1, 255));
      start_v = 8'($urandom_range(0, 255));
      n_ticks = 76;
      case (p)
        0: begin
          // Smallest settings everywhere.
          hold_v = 16'd1; rep_v = 16'd1; deb_v = 8'd1;
          short_v = 8'd1; long_v = 8'd1; max_v = 8'd1; start_v = 8'd0;
          n_ticks = 120;
        end
        1: begin
          // Largest settings: long debounce, no auto repeat in reach.
          hold_v = 16'hFFFF; rep_v = 16'hFFFF; deb_v = 8'd255;
          short_v = 8'd255; long_v = 8'd255; max_v = 8'd255; start_v = 8'd255;
          n_ticks = 400;
        end
        3: begin
          // Reload value above the limit.
          max_v = 8'($urandom_range(1, 100));
          start_v = 8'($urandom_range(150, 255));
        end
        default: ;
      endcase
      in_idle_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      stall_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      write_reg(REG_HOLD_MS, hold_v);
      write_reg(REG_REPEAT_MS, rep_v);
      write_reg(REG_DEBOUNCE_MS, {8'd0, deb_v});
      write_reg(REG_SHORT_STEP, {8'd0, short_v});
      write_reg(REG_LONG_STEP, {8'd0, long_v});
      write_reg(REG_MAX_VALUE, {8'd0, max_v});
      write_reg(REG_START_VALUE, {8'd0, start_v});
      run_phase(n_ticks);
    end

    // Drain and report.
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_setpoints.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("button_setpoint_autorepeat_tb OK");
    end else begin
      $display("button_setpoint_autorepeat_tb NOT OK");
    end
    $finish;
  end

endmodule
